// ===== sv/gtdc_pkg.sv =====
// Shared types, constants and tables of the ground temperature core.
`default_nettype none

package gtdc_pkg;

  localparam int CORDIC_STAGES = 20;
  localparam int TAYLOR_TERMS  = 12;

  localparam logic [24:0] YEAR_SECONDS       = 25'd31536000;
  localparam logic [21:0] MONTH_SECONDS      = 22'd2628000;
  localparam logic [20:0] HALF_MONTH_SECONDS = 21'd1314000;
  localparam logic [56:0] KSQ_NUM            = 57'd120432282903000000;
  localparam logic [29:0] INV_TWO_PI_Q32     = 30'd683565276;
  localparam logic [30:0] LOG2E_Q30          = 31'd1549082005;
  localparam logic [29:0] LN2_Q30            = 30'd744261118;
  localparam logic [29:0] CORDIC_GAIN_Q30    = 30'd652032874;

  // Reciprocals of the year for constant division.
  localparam logic [15:0] YEAR_RECIP_Q40 = 16'((64'd1 << 40) / 64'(YEAR_SECONDS));
  localparam logic [32:0] YEAR_RECIP_Q57 = 33'((64'd1 << 57) / 64'(YEAR_SECONDS));

  // Pipeline latencies.
  localparam int FRONT_LAT  = 9;
  localparam int EXP_LAT    = 3 * TAYLOR_TERMS + 3;
  localparam int CORDIC_LAT = CORDIC_STAGES + 2;
  localparam int ALIGN_LAT  = EXP_LAT - CORDIC_LAT;
  localparam int FINAL_LAT  = 3;
  localparam int PIPE_LAT   = FRONT_LAT + EXP_LAT + FINAL_LAT;

  typedef enum logic [1:0] {
    CFG_MEAN_TEMP,
    CFG_SWING_AMPLITUDE,
    CFG_SOIL_DIFFUSIVITY,
    CFG_PHASE_SHIFT
  } cfg_index_t;

  typedef enum logic [1:0] {
    KC_DIV,
    KC_SQRT,
    KC_DONE
  } kc_state_t;

  typedef struct packed {
    logic        action;
    logic [15:0] depth;
    logic [31:0] time_seconds;
    logic [3:0]  month;
  } gtdc_in_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic               bad_month;
  } gtdc_out_t;

  typedef struct packed {
    logic [31:0] phase;
    logic [24:0] xq;
    logic        big;
    logic        bad;
  } gtdc_front_t;

  typedef logic [CORDIC_STAGES-1:0][31:0] atan_tbl_t;

  // atan(2^-i) in 32-bit turns, from the integer arctangent series in Q60.
  function automatic atan_tbl_t build_atan_tbl();
    atan_tbl_t   tbl;
    logic [63:0] acc;
    logic [63:0] term;
    int          sh;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (i == 0) begin
        tbl[i] = 32'd1 << 29;
      end else begin
        acc = 64'd0;
        for (int n = 0; n < 61; n++) begin
          sh = i * (2 * n + 1);
          if (sh <= 60) begin
            term = ((64'd1 << 60) >> sh) / 64'(2 * n + 1);
            if ((n % 2) == 1) acc = acc - term;
            else              acc = acc + term;
          end
        end
        tbl[i] = 32'(((acc >> 28) * 64'(INV_TWO_PI_Q32)) >> 32);
      end
    end
    return tbl;
  endfunction

  localparam atan_tbl_t ATAN_TBL = build_atan_tbl();

endpackage

`default_nettype wire

// ===== sv/gtdc_kcalc.sv =====
// Sequential divider and square root that derive the depth damping constant.
`default_nettype none

module gtdc_kcalc import gtdc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [23:0] diffusivity,
  output logic      [28:0] kq,
  output logic             k_ready
);

  localparam int DIV_BITS   = 57;
  localparam int SQRT_STEPS = 29;

  kc_state_t   state, state_next;
  logic [5:0]  cnt;
  logic [24:0] rem;
  logic [57:0] acc;
  logic [28:0] root;
  logic [31:0] srem;

  logic [23:0] divisor;
  logic [5:0]  kidx;
  logic [25:0] dshift;
  logic        dge;
  logic [31:0] sshift;
  logic [31:0] trial;
  logic        sge;

  assign divisor = (diffusivity == 24'd0) ? 24'd1 : diffusivity;
  assign kidx    = 6'(DIV_BITS - 1) - cnt;
  assign dshift  = {rem, KSQ_NUM[kidx]};
  assign dge     = dshift >= {2'b00, divisor};
  assign sshift  = {srem[29:0], acc[57:56]};
  assign trial   = {1'b0, root, 2'b01};
  assign sge     = sshift >= trial;

  always_comb begin
    state_next = state;
    priority if (start) begin
      state_next = KC_DIV;
    end else begin
      unique case (state)
        KC_DIV:  if (cnt == 6'(DIV_BITS - 1)) state_next = KC_SQRT;
        KC_SQRT: if (cnt == 6'(SQRT_STEPS - 1)) state_next = KC_DONE;
        KC_DONE: state_next = KC_DONE;
        default: state_next = KC_DIV;
      endcase
    end
  end

  always_comb begin
    k_ready = (state == KC_DONE);
    kq      = root;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= KC_DIV;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      cnt  <= '0;
      rem  <= '0;
      acc  <= '0;
      root <= '0;
      srem <= '0;
    end else begin
      unique case (state)
        KC_DIV: begin
          rem <= dge ? 25'(dshift - {2'b00, divisor}) : dshift[24:0];
          acc <= {acc[56:0], dge};
          cnt <= (cnt == 6'(DIV_BITS - 1)) ? 6'd0 : cnt + 6'd1;
        end
        KC_SQRT: begin
          srem <= sge ? sshift - trial : sshift;
          root <= {root[27:0], sge};
          acc  <= {acc[55:0], 2'b00};
          cnt  <= cnt + 6'd1;
        end
        KC_DONE: cnt <= cnt;
        default: cnt <= '0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/gtdc_front.sv =====
// Front pipeline: time reduction, year angle, depth lag and damping argument.
`default_nettype none

module gtdc_front import gtdc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire gtdc_in_t    in_word,
  input  wire logic [28:0] kq,
  input  wire logic [24:0] phase_shift,
  output gtdc_front_t      front
);

  logic [24:0] pm;
  logic [31:0] month_t;
  logic        bad_in;

  logic [31:0] s1_t;
  logic [15:0] s1_depth;
  logic        s1_bad;

  logic [7:0]  s2_q;
  logic [31:0] s2_t;
  logic [36:0] s2_xq;
  logic        s2_bad;

  logic [25:0] s3_r;
  logic [24:0] s3_xq;
  logic        s3_big, s3_bad;

  logic [24:0] s4_tm;
  logic [24:0] s4_xq;
  logic        s4_big, s4_bad;

  logic [24:0] s5_d;
  logic [31:0] s5_lag;
  logic [24:0] s5_xq;
  logic        s5_big, s5_bad;

  logic [31:0] s6_qe, s6_lag;
  logic [24:0] s6_xq;
  logic        s6_big, s6_bad;

  logic [31:0] s7_qe, s7_lag;
  logic [25:0] s7_pl;
  logic [24:0] s7_xq;
  logic        s7_big, s7_bad;

  logic [31:0] s8_turn, s8_lag;
  logic [24:0] s8_xq;
  logic        s8_big, s8_bad;

  logic [47:0] q1_prod;
  logic [44:0] xq_prod;
  logic [31:0] yq;
  logic [54:0] lag_prod;
  logic [57:0] qe_prod;
  logic [25:0] rem26;

  // Fold a phase shift beyond one year back into the year.
  assign pm = (phase_shift >= YEAR_SECONDS) ? phase_shift - YEAR_SECONDS : phase_shift;

  assign month_t = 32'(32'(MONTH_SECONDS) * 32'(in_word.month)) - 32'(HALF_MONTH_SECONDS);
  assign bad_in  = in_word.action && ((in_word.month == 4'd0) || (in_word.month > 4'd12));

  assign q1_prod  = 48'(s1_t) * 48'(YEAR_RECIP_Q40);
  assign xq_prod  = 45'(s1_depth) * 45'(kq);
  assign yq       = 32'(s2_q) * 32'(YEAR_SECONDS);
  assign lag_prod = 55'(s4_xq) * 55'(INV_TWO_PI_Q32);
  assign qe_prod  = 58'(s5_d) * 58'(YEAR_RECIP_Q57);
  assign rem26    = 26'd0 - s7_pl;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_t     <= in_word.action ? month_t : in_word.time_seconds;
      s1_depth <= in_word.depth;
      s1_bad   <= bad_in;

      s2_q   <= q1_prod[47:40];
      s2_t   <= s1_t;
      s2_xq  <= xq_prod[44:8];
      s2_bad <= s1_bad;

      s3_r   <= 26'(s2_t - yq);
      s3_xq  <= s2_xq[24:0];
      s3_big <= |s2_xq[36:25];
      s3_bad <= s2_bad;

      s4_tm  <= (s3_r >= 26'(YEAR_SECONDS)) ? 25'(s3_r - 26'(YEAR_SECONDS)) : s3_r[24:0];
      s4_xq  <= s3_xq;
      s4_big <= s3_big;
      s4_bad <= s3_bad;

      s5_d   <= (s4_tm >= pm) ? s4_tm - pm
                              : 25'(26'(s4_tm) + 26'(YEAR_SECONDS) - 26'(pm));
      s5_lag <= lag_prod[51:20];
      s5_xq  <= s4_xq;
      s5_big <= s4_big;
      s5_bad <= s4_bad;

      s6_qe  <= qe_prod[56:25];
      s6_lag <= s5_lag;
      s6_xq  <= s5_xq;
      s6_big <= s5_big;
      s6_bad <= s5_bad;

      s7_pl  <= 26'(64'(s6_qe) * 64'(YEAR_SECONDS));
      s7_qe  <= s6_qe;
      s7_lag <= s6_lag;
      s7_xq  <= s6_xq;
      s7_big <= s6_big;
      s7_bad <= s6_bad;

      // Estimate is exact or one low; the remainder tells which.
      s8_turn <= s7_qe + 32'(rem26 >= 26'(YEAR_SECONDS));
      s8_lag  <= s7_lag;
      s8_xq   <= s7_xq;
      s8_big  <= s7_big;
      s8_bad  <= s7_bad;

      front.phase <= s8_turn - s8_lag;
      front.xq    <= s8_xq;
      front.big   <= s8_big;
      front.bad   <= s8_bad;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gtdc_exp.sv =====
// Pipelined exp(-x): base-two split and a truncating Taylor series.
`default_nettype none

module gtdc_exp import gtdc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [24:0] xq,
  input  wire logic        big,
  output logic      [30:0] decay
);

  logic [55:0] w_prod;
  logic [49:0] y_prod;
  logic [5:0]  e1_n;
  logic [19:0] e1_f;
  logic        e1_big;

  logic [30:0] c_term [TAYLOR_TERMS+1];
  logic [31:0] c_acc  [TAYLOR_TERMS+1];
  logic [29:0] c_y    [TAYLOR_TERMS+1];
  logic [5:0]  c_n    [TAYLOR_TERMS+1];
  logic        c_big  [TAYLOR_TERMS+1];

  logic [30:0] a_p    [TAYLOR_TERMS];
  logic [31:0] a_acc  [TAYLOR_TERMS];
  logic [29:0] a_y    [TAYLOR_TERMS];
  logic [5:0]  a_n    [TAYLOR_TERMS];
  logic        a_big  [TAYLOR_TERMS];

  logic [30:0] b_p    [TAYLOR_TERMS];
  logic [30:0] b_qe   [TAYLOR_TERMS];
  logic [31:0] b_acc  [TAYLOR_TERMS];
  logic [29:0] b_y    [TAYLOR_TERMS];
  logic [5:0]  b_n    [TAYLOR_TERMS];
  logic        b_big  [TAYLOR_TERMS];

  assign w_prod = 56'(xq) * 56'(LOG2E_Q30);
  assign y_prod = 50'(e1_f) * 50'(LN2_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      e1_n   <= w_prod[55:50];
      e1_f   <= w_prod[49:30];
      e1_big <= big;

      c_y[0]    <= y_prod[49:20];
      c_n[0]    <= e1_n;
      c_big[0]  <= e1_big;
      c_term[0] <= 31'd1 << 30;
      c_acc[0]  <= 32'd1 << 30;
    end
  end

  for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_term
    localparam logic [32:0] RK  = 33'((64'd1 << 32) / k);
    localparam logic [3:0]  KV  = 4'(k);
    localparam bit          ODD = (k % 2) == 1;

    logic [60:0] mul_p;
    logic [63:0] mul_q;
    logic [34:0] back;
    logic [34:0] rest;
    logic [30:0] term_new;

    assign mul_p    = 61'(c_term[k-1]) * 61'(c_y[k-1]);
    assign mul_q    = 64'(a_p[k-1]) * 64'(RK);
    assign back     = 35'(b_qe[k-1]) * 35'(KV);
    assign rest     = 35'(b_p[k-1]) - back;
    assign term_new = b_qe[k-1] + 31'(rest >= 35'(KV));

    always_ff @(posedge clk) begin
      if (en) begin
        a_p[k-1]   <= mul_p[60:30];
        a_acc[k-1] <= c_acc[k-1];
        a_y[k-1]   <= c_y[k-1];
        a_n[k-1]   <= c_n[k-1];
        a_big[k-1] <= c_big[k-1];

        b_qe[k-1]  <= mul_q[62:32];
        b_p[k-1]   <= a_p[k-1];
        b_acc[k-1] <= a_acc[k-1];
        b_y[k-1]   <= a_y[k-1];
        b_n[k-1]   <= a_n[k-1];
        b_big[k-1] <= a_big[k-1];

        c_term[k] <= term_new;
        c_acc[k]  <= ODD ? b_acc[k-1] - 32'(term_new) : b_acc[k-1] + 32'(term_new);
        c_y[k]    <= b_y[k-1];
        c_n[k]    <= b_n[k-1];
        c_big[k]  <= b_big[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      decay <= c_big[TAYLOR_TERMS] ? 31'd0
                                   : 31'(c_acc[TAYLOR_TERMS] >> c_n[TAYLOR_TERMS]);
    end
  end

endmodule

`default_nettype wire

// ===== sv/gtdc_cordic.sv =====
// Pipelined rotation CORDIC giving the magnitude and sign of a cosine.
`default_nettype none

module gtdc_cordic import gtdc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] phase,
  output logic      [31:0] mag,
  output logic             neg
);

  logic signed [33:0] cx [CORDIC_STAGES+1];
  logic signed [33:0] cy [CORDIC_STAGES+1];
  logic signed [33:0] cz [CORDIC_STAGES+1];
  logic               cf [CORDIC_STAGES+1];

  logic [31:0] psum;
  logic        fold;
  logic [31:0] pfold;

  // Fold angles beyond a quarter turn by a half turn and remember the flip.
  assign psum  = phase + 32'h4000_0000;
  assign fold  = psum[31];
  assign pfold = fold ? phase + 32'h8000_0000 : phase;

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= 34'(CORDIC_GAIN_Q30);
      cy[0] <= '0;
      cz[0] <= {{2{pfold[31]}}, pfold};
      cf[0] <= fold;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [33:0] ANG = 34'(ATAN_TBL[i]);

    logic signed [33:0] dx;
    logic signed [33:0] dy;

    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (cz[i][33]) begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          cz[i+1] <= cz[i] + ANG;
        end else begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          cz[i+1] <= cz[i] - ANG;
        end
        cf[i+1] <= cf[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= cx[CORDIC_STAGES][33] ? 32'(-cx[CORDIC_STAGES]) : 32'(cx[CORDIC_STAGES]);
      neg <= cf[CORDIC_STAGES] ^ cx[CORDIC_STAGES][33];
    end
  end

endmodule

`default_nettype wire

// ===== sv/ground_temperature_damped_cosine_core.sv =====
// Top level of the damped annual cosine ground temperature core.
//
//   channel | signals                          | moves
//   --------+----------------------------------+-------------------------------
//   input   | in_valid, in_ready, in_word      | one query word per handshake
//   output  | out_valid, out_ready, out_word   | one temperature word per query
//   config  | cfg_we, cfg_index, cfg_data      | one register write per cycle
//
// One word enters per cycle once the damping constant is ready and the output
// is not stalled. The longest leg is the 12-term Taylor series of the decay,
// three stages per term. After reset, and after each write of the soil
// diffusivity, a serial divider and square root run; in_ready stays low
// meanwhile. A stalled output freezes the whole pipeline: no word is dropped
// or repeated.
`default_nettype none

module ground_temperature_damped_cosine_core import gtdc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire gtdc_in_t    in_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output gtdc_out_t        out_word,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [24:0] cfg_data
);

  // Configuration registers.
  logic signed [15:0] mean_temp;
  logic [15:0]        swing_amplitude;
  logic [23:0]        soil_diffusivity;
  logic [24:0]        phase_shift;

  logic        en;
  logic        k_ready;
  logic [28:0] kq;
  logic        k_start;

  logic [PIPE_LAT-1:0] vld;

  gtdc_front_t front;
  logic [30:0] decay;
  logic [31:0] cmag;
  logic        cneg;

  logic [31:0] al_mag [ALIGN_LAT];
  logic        al_neg [ALIGN_LAT];
  logic        bd     [EXP_LAT];

  logic [30:0] f1_p;
  logic [31:0] f1_mag;
  logic        f1_neg, f1_bad;
  logic [62:0] f2_prod;
  logic        f2_neg, f2_bad;

  logic [46:0]        sa_prod;
  logic [63:0]        rsum;
  logic [19:0]        r;
  logic signed [20:0] temp;
  logic signed [15:0] temp_sat;

  // Advance everything unless a finished word waits on a stalled output.
  assign en        = !out_valid || out_ready;
  assign in_ready  = en && k_ready;
  assign out_valid = vld[PIPE_LAT-1];
  assign k_start   = cfg_we && (cfg_index == CFG_SOIL_DIFFUSIVITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_temp        <= 16'sd3840;
      swing_amplitude  <= 16'd2560;
      soil_diffusivity <= 24'd821000;
      phase_shift      <= 25'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MEAN_TEMP:        mean_temp        <= cfg_data[15:0];
        CFG_SWING_AMPLITUDE:  swing_amplitude  <= cfg_data[15:0];
        CFG_SOIL_DIFFUSIVITY: soil_diffusivity <= cfg_data[23:0];
        CFG_PHASE_SHIFT:      phase_shift      <= cfg_data;
        default:              mean_temp        <= mean_temp;
      endcase
    end
  end

  // Hold a valid bit next to each pipeline stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid && in_ready};
    end
  end

  gtdc_kcalc u_kcalc (
    .clk         (clk),
    .rst         (rst),
    .start       (k_start),
    .diffusivity (soil_diffusivity),
    .kq          (kq),
    .k_ready     (k_ready)
  );

  gtdc_front u_front (
    .clk         (clk),
    .en          (en),
    .in_word     (in_word),
    .kq          (kq),
    .phase_shift (phase_shift),
    .front       (front)
  );

  gtdc_exp u_exp (
    .clk   (clk),
    .en    (en),
    .xq    (front.xq),
    .big   (front.big),
    .decay (decay)
  );

  gtdc_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .phase (front.phase),
    .mag   (cmag),
    .neg   (cneg)
  );

  // Delay the cosine and the month flag to meet the decay.
  always_ff @(posedge clk) begin
    if (en) begin
      al_mag[0] <= cmag;
      al_neg[0] <= cneg;
      for (int i = 1; i < ALIGN_LAT; i++) begin
        al_mag[i] <= al_mag[i-1];
        al_neg[i] <= al_neg[i-1];
      end
      bd[0] <= front.bad;
      for (int i = 1; i < EXP_LAT; i++) begin
        bd[i] <= bd[i-1];
      end
    end
  end

  assign sa_prod = 47'(swing_amplitude) * 47'(decay);
  assign rsum    = 64'(f2_prod) + (64'd1 << 43);
  assign r       = rsum[63:44];

  always_comb begin
    if (f2_neg) temp = 21'(mean_temp) + 21'(r);
    else        temp = 21'(mean_temp) - 21'(r);
    priority if (temp > 21'sd32767) begin
      temp_sat = 16'sh7FFF;
    end else if (temp < -21'sd32768) begin
      temp_sat = -16'sh8000;
    end else begin
      temp_sat = temp[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_p   <= sa_prod[46:16];
      f1_mag <= al_mag[ALIGN_LAT-1];
      f1_neg <= al_neg[ALIGN_LAT-1];
      f1_bad <= bd[EXP_LAT-1];

      f2_prod <= 63'(f1_p) * 63'(f1_mag);
      f2_neg  <= f1_neg;
      f2_bad  <= f1_bad;

      // Drop the temperature to zero and flag a month outside the year.
      out_word.temperature <= f2_bad ? 16'sd0 : temp_sat;
      out_word.bad_month   <= f2_bad;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gtdc_checker.sv =====
// Port-level checker for the ground temperature core, bound to the top level.
`default_nettype none

module gtdc_checker import gtdc_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire gtdc_out_t   out_word,
  input wire logic        cfg_we,
  input wire logic [1:0]  cfg_index
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // A flagged month carries a zero temperature.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.bad_month |-> out_word.temperature == 16'sd0)
    else $error("bad month with nonzero temperature");

  // The damping constant is rebuilt after reset.
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input taken before damping constant is ready");

  // A diffusivity write restarts the damping constant.
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == CFG_SOIL_DIFFUSIVITY) |=> !in_ready)
    else $error("input taken right after diffusivity write");

endmodule

bind ground_temperature_damped_cosine_core gtdc_checker u_gtdc_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the damped annual cosine ground temperature core.
`timescale 1ns / 1ps

module testbench import gtdc_pkg::*;;

  localparam int  CYCLE_LIMIT = 600000;
  localparam int  QUIET_FROM  = 800;     // window with no idling on either side
  localparam int  QUIET_TO    = 1600;
  localparam int  TAIL_WAIT   = PIPE_LAT + 10;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  gtdc_in_t    in_word;
  logic        out_valid;
  logic        out_ready;
  gtdc_out_t   out_word;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [24:0] cfg_data;

  ground_temperature_damped_cosine_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copies of the configuration registers, updated on every write.
  logic [15:0] sh_mean;
  logic [15:0] sh_swing;
  logic [23:0] sh_diff;
  logic [24:0] sh_shift;

  gtdc_in_t  query_queue[$];    // words waiting to be driven
  gtdc_out_t temp_queue[$];     // predicted results, oldest first
  int        fails = 0;
  int        cycle = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // atan(2^-i) in 32-bit turns via the Q60 arctangent series
  function automatic logic [63:0] atan_turn(int i);
    logic [63:0] acc;
    logic [63:0] term;
    int          sh;
    acc = 64'd0;
    if (i == 0) return 64'd1 << 29;
    for (int n = 0; ; n++) begin
      sh = i * (2 * n + 1);
      if (sh > 60) break;
      term = ((64'd1 << 60) >> sh) / 64'(2 * n + 1);
      if (n % 2 == 1) acc = acc - term;
      else            acc = acc + term;
    end
    return ((acc >> 28) * 64'(INV_TWO_PI_Q32)) >> 32;
  endfunction

  // exp(-x) in Q30, x in Q20
  function automatic logic [63:0] decay_q30(logic [63:0] xq);
    logic [63:0] w;
    logic [63:0] n;
    logic [63:0] y;
    logic [63:0] acc;
    logic [63:0] term;
    w    = (xq * 64'(LOG2E_Q30)) >> 30;
    n    = w >> 20;
    y    = ((w & 64'hFFFFF) * 64'(LN2_Q30)) >> 20;
    acc  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * y) >> 30) / 64'(k);
      if (k % 2 == 1) acc = acc - term;
      else            acc = acc + term;
    end
    return (n < 64) ? (acc >> n) : 64'd0;
  endfunction

  // |cos| in Q30 of a turn angle; neg carries the sign
  function automatic logic [63:0] cos_q30(logic [63:0] p, output logic neg);
    logic        flip;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] a;
    logic [63:0] dx;
    logic [63:0] dy;
    flip = 1'b0;
    x    = 64'(CORDIC_GAIN_Q30);
    y    = 64'd0;
    p    = p & 64'hFFFFFFFF;
    // fold into -1/4..1/4 turn
    if (((p + 64'h40000000) >> 31) & 64'd1) begin
      flip = 1'b1;
      p    = (p + 64'h80000000) & 64'hFFFFFFFF;
    end
    z = p[31] ? {32'hFFFFFFFF, p[31:0]} : p;
    for (int i = 0; i < CORDIC_STAGES && i < 62; i++) begin
      a  = atan_turn(i);
      dx = $signed(y) >>> i;
      dy = $signed(x) >>> i;
      if (z[63]) begin
        x = x + dx; y = y - dy; z = z + a;
      end else begin
        x = x - dx; y = y + dy; z = z - a;
      end
    end
    if (x[63]) begin
      flip = !flip;
      x    = 64'd0 - x;
    end
    neg = flip;
    return x;
  endfunction

  function automatic gtdc_out_t ground_temp(gtdc_in_t w);
    gtdc_out_t   res;
    logic [63:0] t;
    logic [63:0] d;
    logic [63:0] tturn;
    logic [63:0] diff;
    logic [63:0] kq;
    logic [63:0] xq;
    logic [63:0] lag;
    logic [63:0] decay;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] r;
    logic        neg;
    longint      temp;
    res   = '0;
    decay = 64'd0;
    mag   = 64'd0;
    neg   = 1'b0;
    t     = 64'(w.time_seconds);
    if (w.action) begin
      if (w.month < 4'd1 || w.month > 4'd12) begin
        res.temperature = 16'sd0;
        res.bad_month   = 1'b1;
        return res;
      end
      // middle of the month
      t = 64'(MONTH_SECONDS) * 64'(w.month) - 64'(HALF_MONTH_SECONDS);
    end
    d = (t % 64'(YEAR_SECONDS) + 64'(YEAR_SECONDS) - 64'(sh_shift) % 64'(YEAR_SECONDS))
        % 64'(YEAR_SECONDS);
    tturn = (d << 32) / 64'(YEAR_SECONDS);
    diff  = (sh_diff != 24'd0) ? 64'(sh_diff) : 64'd1;
    kq    = int_sqrt(64'(KSQ_NUM) / diff);
    xq    = (64'(w.depth) * kq) >> 8;
    if (xq < (64'd32 << 20)) begin
      lag   = (xq * 64'(INV_TWO_PI_Q32)) >> 20;
      decay = decay_q30(xq);
      mag   = cos_q30((tturn - lag) & 64'hFFFFFFFF, neg);
    end
    prod = ((64'(sh_swing) * decay) >> 16) * mag;
    r    = (prod + (64'd1 << 43)) >> 44;
    temp = longint'($signed(sh_mean));
    if (neg) temp = temp + longint'(r);
    else     temp = temp - longint'(r);
    if (temp > 32767)  temp = 32767;
    if (temp < -32768) temp = -32768;
    res.temperature = temp[15:0];
    res.bad_month   = 1'b0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feeds query words from the queue, idling at random
  // ---------------------------------------------------------------------------

  function automatic logic idle_now();
    if (cycle >= QUIET_FROM && cycle < QUIET_TO) return 1'b0;
    return $urandom_range(99) < 20;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_word  <= '0;
    end else begin
      // predict at acceptance; config only changes while idle
      if (in_valid && in_ready) temp_queue.push_back(ground_temp(in_word));
      // hold the word until it is taken
      if (!in_valid || in_ready) begin
        if (query_queue.size() > 0 && !idle_now()) begin
          in_valid <= 1'b1;
          in_word  <= query_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stalls at random and checks each result word against the oldest
  // prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (temp_queue.size() == 0) begin
          $display("%0t: unexpected result temperature=%0d bad_month=%0b", $time,
                   out_word.temperature, out_word.bad_month);
          fails++;
        end else begin
          if (out_word.temperature !== temp_queue[0].temperature) begin
            $display("%0t: temperature expected %0d actual %0d", $time,
                     temp_queue[0].temperature, out_word.temperature);
            fails++;
          end
          if (out_word.bad_month !== temp_queue[0].bad_month) begin
            $display("%0t: bad_month expected %0b actual %0b", $time,
                     temp_queue[0].bad_month, out_word.bad_month);
            fails++;
          end
          void'(temp_queue.pop_front());
        end
      end
      out_ready <= !idle_now();
    end
  end

  // Cycle counter and run limit
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic write_reg(cfg_index_t idx, logic [24:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_MEAN_TEMP:        sh_mean  = val[15:0];
      CFG_SWING_AMPLITUDE:  sh_swing = val[15:0];
      CFG_SOIL_DIFFUSIVITY: sh_diff  = val[23:0];
      default:              sh_shift = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] m, logic [15:0] s, logic [23:0] dif,
                            logic [24:0] ph);
    write_reg(CFG_MEAN_TEMP, 25'(m));
    write_reg(CFG_SWING_AMPLITUDE, 25'(s));
    write_reg(CFG_SOIL_DIFFUSIVITY, 25'(dif));
    write_reg(CFG_PHASE_SHIFT, ph);
  endtask

  task automatic add_query(logic act, logic [15:0] dep, logic [31:0] ts, logic [3:0] mon);
    gtdc_in_t w;
    w.action       = act;
    w.depth        = dep;
    w.time_seconds = ts;
    w.month        = mon;
    query_queue.push_back(w);
  endtask

  // Drain: wait until every word is sent and every result has come back.
  task automatic drain();
    do @(posedge clk);
    while (query_queue.size() != 0 || in_valid || temp_queue.size() != 0);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  task automatic random_queries(int count);
    logic [15:0] dep;
    logic [3:0]  mon;
    int          sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(9);
      // mostly shallow depths where the swing is visible; some anywhere
      if (sel < 5)      dep = 16'($urandom_range(4095));
      else if (sel < 8) dep = 16'($urandom_range(32767));
      else              dep = 16'($urandom);
      mon = ($urandom_range(9) < 8) ? 4'($urandom_range(12, 1)) : 4'($urandom);
      add_query(1'($urandom), dep, $urandom, mon);
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    sh_mean   = 16'd3840;
    sh_swing  = 16'd2560;
    sh_diff   = 24'd821000;
    sh_shift  = 25'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed words at reset settings
    add_query(1'b0, 16'd0, 32'd0, 4'd0);
    add_query(1'b0, 16'd0, 32'hFFFFFFFF, 4'd15);     // long time, month ignored
    add_query(1'b0, 16'd65535, 32'd7884000, 4'd0);   // deep damping
    add_query(1'b0, 16'd256, 32'd31535999, 4'd5);
    add_query(1'b0, 16'd512, 32'd31536000, 4'd0);
    add_query(1'b1, 16'd0, 32'd0, 4'd0);             // bad month
    add_query(1'b1, 16'd100, 32'd0, 4'd13);
    add_query(1'b1, 16'd100, 32'hFFFFFFFF, 4'd15);
    add_query(1'b1, 16'd0, 32'd0, 4'd1);
    add_query(1'b1, 16'd0, 32'd0, 4'd12);
    add_query(1'b1, 16'd1280, 32'd0, 4'd7);
    add_query(1'b1, 16'd65535, 32'd0, 4'd6);
    add_query(1'b0, 16'd22000, 32'd15768000, 4'd0);
    add_query(1'b0, 16'hAAAA, 32'h55555555, 4'hA);
    add_query(1'b0, 16'h5555, 32'hAAAAAAAA, 4'h5);
    drain();

    // Extremes of the settings, with a few directed words each
    set_config(16'h8000, 16'hFFFF, 24'd1, 25'd31536000);
    add_query(1'b0, 16'd0, 32'd0, 4'd0);
    add_query(1'b1, 16'd65535, 32'd0, 4'd3);
    random_queries(80);
    drain();

    set_config(16'h7FFF, 16'hFFFF, 24'hFFFFFF, 25'd0);
    add_query(1'b0, 16'd0, 32'd15768000, 4'd0);
    random_queries(80);
    drain();

    // zero diffusivity and a phase shift past a year
    set_config(16'd0, 16'hFFFF, 24'd0, 25'h1FFFFFF);
    random_queries(80);
    drain();

    set_config(16'd3840, 16'd0, 24'd821000, 25'd1000);
    random_queries(60);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_config(16'($urandom), 16'($urandom), 24'($urandom_range(24'hFFFFFF, 1)),
                 25'($urandom_range(31536000)));
      random_queries(85);
      drain();
    end

    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== ground_temperature_damped_cosine_core.f =====
sv/gtdc_pkg.sv
sv/gtdc_kcalc.sv
sv/gtdc_front.sv
sv/gtdc_exp.sv
sv/gtdc_cordic.sv
sv/ground_temperature_damped_cosine_core.sv
sv/gtdc_checker.sv
tb/testbench.sv
